// ===== rtl/yuyv422_to_i420_converter_assert.svh =====
// Assertion macros shared by the checker files of this project.
`ifndef YUYV422_TO_I420_CONVERTER_ASSERT_SVH
`define YUYV422_TO_I420_CONVERTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define YTI_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define YTI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/yti_pkg.sv =====
package yti_pkg;

   localparam int SAMPLE_W     = 8;
   localparam int OFFSET_W     = 24;
   localparam int CFG_W        = 13;
   localparam int CSR_INDEX_W  = 2;
   localparam int PLANE_W      = 2;
   localparam int REQ_DATA_W   = 4 * SAMPLE_W;
   localparam int RSP_DATA_W   = OFFSET_W + SAMPLE_W;
   localparam int RSP_USER_W   = PLANE_W + 1;
   localparam int EFF_W        = CFG_W + 1;

   // Destination planes.
   localparam logic [PLANE_W-1:0] PLANE_Y  = 2'd0;
   localparam logic [PLANE_W-1:0] PLANE_CB = 2'd1;
   localparam logic [PLANE_W-1:0] PLANE_CR = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   // One macropixel held while its result bytes are sent out.
   typedef struct packed {
      logic [SAMPLE_W-1:0] luma_first;
      logic [SAMPLE_W-1:0] chroma_blue;
      logic [SAMPLE_W-1:0] luma_second;
      logic [SAMPLE_W-1:0] chroma_red;
      logic [OFFSET_W-1:0] luma_offset;
      logic [OFFSET_W-1:0] chroma_offset;
      logic                odd_row;
      logic                frame_end;
   } item_type;

endpackage

// ===== rtl/yuyv422_to_i420_converter.sv =====
// Output: the bytes of a macropixel pass through the serializer stage and then the output
// register after its transaction is accepted, one per cycle while rsp_tready stays high.
// Even rows give two planar bytes per macropixel, odd rows four; the next macropixel is
// taken as the last byte of the current one leaves the serializer for the output register.
// Reset (synchronous, active high) clears the counters, handshakes and registers to
// 1920 x 1080; the chroma line memory is not cleared and needs no clearing pass.
module yuyv422_to_i420_converter #(
   parameter int MAX_LINE_WIDTH   = 4096,
   parameter int MAX_FRAME_HEIGHT = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   // Macropixel input. tdata from bit 0: luma_first, chroma_blue, luma_second, chroma_red.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [yti_pkg::REQ_DATA_W-1:0]    req_tdata,
   // Planar bytes out. tdata from bit 0: plane_offset, byte_value.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [yti_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // tuser from bit 0: plane_sel, frame_done.
   output logic [yti_pkg::RSP_USER_W-1:0]    rsp_tuser,
   // tlast marks the last byte produced by one macropixel.
   output logic                              rsp_tlast,
   // Register writes.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [yti_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [yti_pkg::CFG_W-1:0]         csr_data
);

   // One chroma line memory entry per macropixel column; the column counter is its address.
   localparam int STORE_DEPTH = MAX_LINE_WIDTH / 2;
   localparam int CW          = $clog2(STORE_DEPTH);
   localparam int RW          = $clog2(MAX_FRAME_HEIGHT);
   localparam int SW          = yti_pkg::SAMPLE_W;
   localparam int OW          = yti_pkg::OFFSET_W;
   localparam int EW          = yti_pkg::EFF_W;

   // Output step codes within one macropixel.
   localparam logic [1:0] STEP_LUMA0 = 2'd0;
   localparam logic [1:0] STEP_LUMA1 = 2'd1;
   localparam logic [1:0] STEP_CB    = 2'd2;
   localparam logic [1:0] STEP_CR    = 2'd3;

   // Clamp a register value into [2, hi] and force it even.
   function automatic logic [EW-1:0] clamp_even(input logic [yti_pkg::CFG_W-1:0] v,
                                                input logic [EW-1:0] hi);
      logic [EW-1:0] t;
      t = {1'b0, v};
      if (t < EW'(2)) t = EW'(2);
      if (t > hi) t = hi;
      return {t[EW-1:1], 1'b0};
   endfunction

   // Configuration registers.
   logic [yti_pkg::CFG_W-1:0] line_width_ff;
   logic [yti_pkg::CFG_W-1:0] frame_height_ff;
   logic                      csr_write;
   logic                      csr_hit;

   // Position counters and the plane base offsets of the current row.
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [OW-1:0] ybase_ff, ybase_in;
   logic [OW-1:0] cbase_ff, cbase_in;

   // Serializer stage: one macropixel and the step of its next byte.
   logic                  s1_valid_ff, s1_valid_in;
   logic [1:0]            s1_step_ff, s1_step_in;
   yti_pkg::item_type     s1_item_ff, s1_item_in;

   // Output register.
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [yti_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [yti_pkg::RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;
   logic                           rsp_last_ff, rsp_last_in;

   // Chroma line memory, {Cb, Cr} per entry, and its registered read data.
   logic [2*SW-1:0] chroma_mem [STORE_DEPTH];
   logic [2*SW-1:0] chroma_rd_ff;

   logic [EW-1:0]   width_eff;
   logic [EW-1:0]   height_eff;
   logic [EW-1:0]   pairs;
   logic [EW-1:0]   col_plus;
   logic [EW-1:0]   row_plus;
   logic            end_line;
   logic            end_frame;
   logic            req_accept;
   logic            out_load;
   logic            s1_fire;
   logic            s1_last_step;
   logic            s1_done;
   logic [SW:0]     sum_cb;
   logic [SW:0]     sum_cr;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   // A write to either register restarts the frame at the next transaction.
   assign csr_hit   = csr_write && ((csr_index == yti_pkg::CSR_LINE_WIDTH) ||
                                    (csr_index == yti_pkg::CSR_FRAME_HEIGHT));

   assign width_eff  = clamp_even(line_width_ff, EW'(MAX_LINE_WIDTH));
   assign height_eff = clamp_even(frame_height_ff, EW'(MAX_FRAME_HEIGHT));
   assign pairs      = width_eff >> 1;

   assign col_plus  = EW'(col_ff) + EW'(1);
   assign row_plus  = EW'(row_ff) + EW'(1);
   assign end_line  = col_plus >= pairs;
   assign end_frame = end_line && (row_plus >= height_eff);

   // The serializer hands the output register one byte whenever that register is free or
   // being emptied. A new macropixel enters as the last byte of the current one leaves.
   assign out_load     = !rsp_valid_ff || rsp_tready;
   assign s1_fire      = s1_valid_ff && out_load;
   assign s1_last_step = s1_item_ff.odd_row ? (s1_step_ff == STEP_CR)
                                            : (s1_step_ff == STEP_LUMA1);
   assign s1_done      = s1_fire && s1_last_step;
   assign req_tready   = !s1_valid_ff || s1_done;
   assign req_accept   = req_tvalid && req_tready;

   // Counter and base-offset update on each accepted transaction.
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      ybase_in = ybase_ff;
      cbase_in = cbase_ff;
      if (csr_hit) begin
         col_in   = '0;
         row_in   = '0;
         ybase_in = '0;
         cbase_in = '0;
      end else if (req_accept) begin
         if (!end_line) begin
            col_in = CW'(col_plus);
         end else if (end_frame) begin
            col_in   = '0;
            row_in   = '0;
            ybase_in = '0;
            cbase_in = '0;
         end else begin
            col_in   = '0;
            row_in   = RW'(row_plus);
            ybase_in = ybase_ff + OW'(width_eff);
            // The chroma planes advance by one row after every odd luma row.
            if (row_ff[0]) begin
               cbase_in = cbase_ff + OW'(pairs);
            end
         end
      end
   end

   // Serializer stage.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_step_in  = s1_step_ff;
      s1_item_in  = s1_item_ff;
      if (req_accept) begin
         s1_valid_in              = 1'b1;
         s1_step_in               = STEP_LUMA0;
         s1_item_in.luma_first    = req_tdata[SW-1:0];
         s1_item_in.chroma_blue   = req_tdata[2*SW-1:SW];
         s1_item_in.luma_second   = req_tdata[3*SW-1:2*SW];
         s1_item_in.chroma_red    = req_tdata[4*SW-1:3*SW];
         s1_item_in.luma_offset   = ybase_ff + OW'({col_ff, 1'b0});
         s1_item_in.chroma_offset = cbase_ff + OW'(col_ff);
         s1_item_in.odd_row       = row_ff[0];
         s1_item_in.frame_end     = end_frame;
      end else if (s1_done) begin
         s1_valid_in = 1'b0;
      end else if (s1_fire) begin
         s1_step_in = s1_step_ff + 2'd1;
      end
   end

   // Truncating averages of the stored even-row chroma with the current one. The read data
   // was registered at the accepting edge and stays put until the next transaction.
   assign sum_cb = {1'b0, chroma_rd_ff[2*SW-1:SW]} + {1'b0, s1_item_ff.chroma_blue};
   assign sum_cr = {1'b0, chroma_rd_ff[SW-1:0]} + {1'b0, s1_item_ff.chroma_red};

   // Byte selection for the output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = s1_valid_ff;
         case (s1_step_ff)
            STEP_LUMA0: begin
               rsp_data_in = {s1_item_ff.luma_first, s1_item_ff.luma_offset};
               rsp_user_in = {1'b0, yti_pkg::PLANE_Y};
               rsp_last_in = 1'b0;
            end
            STEP_LUMA1: begin
               // The luma offset is always even, so the right pixel sits at bit 0 set.
               rsp_data_in = {s1_item_ff.luma_second,
                              s1_item_ff.luma_offset[OW-1:1], 1'b1};
               rsp_user_in = {!s1_item_ff.odd_row && s1_item_ff.frame_end,
                              yti_pkg::PLANE_Y};
               rsp_last_in = !s1_item_ff.odd_row;
            end
            STEP_CB: begin
               rsp_data_in = {sum_cb[SW:1], s1_item_ff.chroma_offset};
               rsp_user_in = {1'b0, yti_pkg::PLANE_CB};
               rsp_last_in = 1'b0;
            end
            STEP_CR: begin
               rsp_data_in = {sum_cr[SW:1], s1_item_ff.chroma_offset};
               rsp_user_in = {s1_item_ff.frame_end, yti_pkg::PLANE_CR};
               rsp_last_in = 1'b1;
            end
            default: begin
               rsp_data_in = rsp_data_ff;
               rsp_user_in = rsp_user_ff;
               rsp_last_in = rsp_last_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= yti_pkg::CFG_W'(1920);
         frame_height_ff <= yti_pkg::CFG_W'(1080);
         col_ff          <= '0;
         row_ff          <= '0;
         ybase_ff        <= '0;
         cbase_ff        <= '0;
         s1_valid_ff     <= 1'b0;
         s1_step_ff      <= STEP_LUMA0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write && (csr_index == yti_pkg::CSR_LINE_WIDTH)) begin
            line_width_ff <= csr_data;
         end
         if (csr_write && (csr_index == yti_pkg::CSR_FRAME_HEIGHT)) begin
            frame_height_ff <= csr_data;
         end
         col_ff       <= col_in;
         row_ff       <= row_in;
         ybase_ff     <= ybase_in;
         cbase_ff     <= cbase_in;
         s1_valid_ff  <= s1_valid_in;
         s1_step_ff   <= s1_step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Even rows store their chroma; odd rows read what the row above stored. Reads and writes
   // never hit one entry in the same cycle, and a write is complete before any later read,
   // so no forwarding is needed.
   always_ff @(posedge clock) begin
      if (req_accept && !row_ff[0]) begin
         chroma_mem[col_ff] <= {req_tdata[2*SW-1:SW], req_tdata[4*SW-1:3*SW]};
      end
      if (req_accept && row_ff[0]) begin
         chroma_rd_ff <= chroma_mem[col_ff];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/yti_checker.sv =====
`include "yuyv422_to_i420_converter_assert.svh"

module yti_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [yti_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [yti_pkg::RSP_USER_W-1:0] rsp_tuser,
   input logic                           rsp_tlast
);

   logic [yti_pkg::PLANE_W-1:0]                        plane;
   logic [yti_pkg::OFFSET_W-1:0]                       offset;
   logic [yti_pkg::OFFSET_W-1:0]                       last_offset_ff;
   logic [yti_pkg::RSP_DATA_W+yti_pkg::RSP_USER_W+1:0] out_bus;
   logic                                               out_xfer;
   logic                                               out_stall;
   logic                                               is_y;
   logic                                               is_cb;
   logic                                               is_cr;
   logic                                               done_flag;
   logic                                               cr_match;

   assign plane     = rsp_tuser[yti_pkg::PLANE_W-1:0];
   assign offset    = rsp_tdata[yti_pkg::OFFSET_W-1:0];
   assign out_bus   = {rsp_tvalid, rsp_tdata, rsp_tuser, rsp_tlast};
   assign out_xfer  = rsp_tvalid && rsp_tready;
   assign out_stall = rsp_tvalid && !rsp_tready;
   assign is_y      = plane == yti_pkg::PLANE_Y;
   assign is_cb     = plane == yti_pkg::PLANE_CB;
   assign is_cr     = plane == yti_pkg::PLANE_CR;
   assign done_flag = rsp_tuser[yti_pkg::PLANE_W];
   assign cr_match  = rsp_tvalid && is_cr && (offset == last_offset_ff);

   // Offset seen on the previous cycle.
   always_ff @(posedge clock) begin
      last_offset_ff <= offset;
   end

   // A stalled output transaction keeps its contents and stays valid.
   `YTI_ASSERT_NEXT(a_rsp_hold, clock, reset, out_stall, $stable(out_bus), "stalled output moved")

   // Only the three defined planes appear.
   `YTI_ASSERT_SAME(a_plane, clock, reset, rsp_tvalid, is_y || is_cb || is_cr, "bad plane")

   // The end-of-frame flag sits only on the last byte of a macropixel.
   `YTI_ASSERT_SAME(a_done, clock, reset, rsp_tvalid && done_flag, rsp_tlast, "done not last")

   // A Cr byte always closes its macropixel.
   `YTI_ASSERT_SAME(a_cr_last, clock, reset, rsp_tvalid && is_cr, rsp_tlast, "Cr byte not last")

   // Cb is followed at once by Cr at the same chroma offset.
   `YTI_ASSERT_NEXT(a_cb_cr, clock, reset, out_xfer && is_cb, cr_match, "Cr must follow Cb")

endmodule

bind yuyv422_to_i420_converter yti_checker u_yti_checker (.*);

// ===== bench/yuyv422_to_i420_converter_tb.sv =====
`timescale 1ns / 100ps

// Testbench for the YUYV 4:2:2 to I420 planar converter.
//
// A set of named tests runs in turn from one initial block. All of them push
// macropixel transactions through one sender task. That task also feeds a
// predictor, which keeps its own copy of the geometry registers, the pixel and
// line counters and the one-line chroma store. The predictor appends the
// planar bytes it expects to a queue. A separate checker compares every result
// transaction with the oldest entry of that queue, field by field.
//
// The receiver drops tready in random bursts. Once it holds off for a long
// stretch while the sender keeps offering data, so that the block fills up and
// stalls its input. The last part of the run uses no idling on either side.
module yuyv422_to_i420_converter_tb;

   localparam int SW          = yti_pkg::SAMPLE_W;
   localparam int OW          = yti_pkg::OFFSET_W;
   localparam int PW          = yti_pkg::PLANE_W;
   localparam int FW          = yti_pkg::CFG_W;
   localparam int IW          = yti_pkg::CSR_INDEX_W;
   localparam int MAX_W       = 4096;
   localparam int MAX_H       = 4096;
   localparam int STORE_DEPTH = MAX_W / 2;
   localparam int HOLD_CYCLES = 300;
   localparam int MAX_REPORTS = 10;

   // This index addresses no register, so a write to it must change nothing.
   localparam logic [IW-1:0] CSR_UNUSED_INDEX = 2'd3;

   // One planar byte as the block should emit it.
   typedef struct packed {
      logic [PW-1:0] plane;
      logic [OW-1:0] offset;
      logic [SW-1:0] value;
      logic          last;
      logic          done;
   } planar_byte_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;

   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [yti_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [yti_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [yti_pkg::RSP_USER_W-1:0] rsp_tuser;
   logic                           rsp_tlast;
   logic                           csr_valid  = 1'b0;
   logic                           csr_ready;
   logic [IW-1:0]                  csr_index  = '0;
   logic [FW-1:0]                  csr_data   = '0;

   // Random idling on both sides is enabled while this is set.
   bit idle_on = 1'b1;
   // Set by a test to ask the receiver for one long hold-off.
   bit hold_request = 1'b0;

   int failure_count = 0;

   // Predictor state: registers as written, counters and the chroma line.
   logic [FW-1:0]       line_width_reg   = 13'd1920;
   logic [FW-1:0]       frame_height_reg = 13'd1080;
   int unsigned         column_idx = 0;
   int unsigned         row_idx    = 0;
   logic [SW-1:0]       cb_line [STORE_DEPTH];
   logic [SW-1:0]       cr_line [STORE_DEPTH];

   planar_byte_type expected_bytes [$];

   yuyv422_to_i420_converter #(
      .MAX_LINE_WIDTH   (MAX_W),
      .MAX_FRAME_HEIGHT (MAX_H)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      // tdata from bit 0: luma_first, chroma_blue, luma_second, chroma_red.
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // tdata from bit 0: plane_offset, byte_value.
      .rsp_tdata  (rsp_tdata),
      // tuser from bit 0: plane_sel, frame_done.
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin : clock_gen
      forever #1 clock = ~clock;
   end

   // The block clamps a raw register into [2, limit] and then rounds it down
   // to an even value.
   function automatic int unsigned effective_dimension(input logic [FW-1:0] raw,
                                                       input int unsigned limit);
      int unsigned v;
      v = raw;
      if (v < 2) v = 2;
      if (v > limit) v = limit;
      return v & ~32'd1;
   endfunction

   // Works out the planar bytes of one accepted macropixel and advances the
   // predicted counters. Even rows store their chroma; odd rows average it.
   function automatic void predict_macropixel(input logic [SW-1:0] y0, cb, y1, cr);
      int unsigned w, h, pairs, slot, luma_off, chroma_off, cb_avg, cr_avg;
      logic end_line, end_frame;
      w          = effective_dimension(line_width_reg, MAX_W);
      h          = effective_dimension(frame_height_reg, MAX_H);
      pairs      = w / 2;
      slot       = column_idx % STORE_DEPTH;
      end_line   = (column_idx + 1) >= pairs;
      end_frame  = end_line && ((row_idx + 1) >= h);
      luma_off   = row_idx * w + 2 * column_idx;
      chroma_off = (row_idx / 2) * pairs + column_idx;
      expected_bytes.push_back(planar_byte_type'{yti_pkg::PLANE_Y, OW'(luma_off), y0,
                                                 1'b0, 1'b0});
      if (row_idx % 2 == 1) begin
         cb_avg = (int'(cb_line[slot]) + int'(cb)) >> 1;
         cr_avg = (int'(cr_line[slot]) + int'(cr)) >> 1;
         expected_bytes.push_back(planar_byte_type'{yti_pkg::PLANE_Y, OW'(luma_off + 1), y1,
                                                    1'b0, 1'b0});
         expected_bytes.push_back(planar_byte_type'{yti_pkg::PLANE_CB, OW'(chroma_off),
                                                    SW'(cb_avg), 1'b0, 1'b0});
         expected_bytes.push_back(planar_byte_type'{yti_pkg::PLANE_CR, OW'(chroma_off),
                                                    SW'(cr_avg), 1'b1, end_frame});
      end else begin
         cb_line[slot] = cb;
         cr_line[slot] = cr;
         expected_bytes.push_back(planar_byte_type'{yti_pkg::PLANE_Y, OW'(luma_off + 1), y1,
                                                    1'b1, end_frame});
      end
      if (end_line) begin
         column_idx = 0;
         row_idx    = end_frame ? 0 : row_idx + 1;
      end else begin
         column_idx = column_idx + 1;
      end
   endfunction

   task automatic report_failure(input string what);
      failure_count++;
      if (failure_count <= MAX_REPORTS) begin
         $display("%0t: %s", $realtime, what);
      end
   endtask

   // Offers one macropixel and returns at the edge where its transaction is
   // accepted. Valid stays high on return, so a following call can present
   // the next item on the same edge without a bubble.
   task automatic send_macropixel(input logic [SW-1:0] y0, cb, y1, cr);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {cr, y1, cb, y0};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_macropixel(y0, cb, y1, cr);
   endtask

   task automatic send_random_macropixel();
      send_macropixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // Lowers valid and waits until every predicted byte has arrived, then lets
   // the output register empty before anything is reconfigured.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes one register while the block is idle. A write to either geometry
   // register restarts the frame at its first macropixel.
   task automatic write_register(input logic [IW-1:0] index,
                                 input logic [FW-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (index == yti_pkg::CSR_LINE_WIDTH || index == yti_pkg::CSR_FRAME_HEIGHT) begin
         if (index == yti_pkg::CSR_LINE_WIDTH) line_width_reg = value;
         else frame_height_reg = value;
         column_idx = 0;
         row_idx    = 0;
      end
      @(posedge clock);
   endtask

   task automatic set_geometry(input logic [FW-1:0] width, height);
      write_register(yti_pkg::CSR_LINE_WIDTH, width);
      write_register(yti_pkg::CSR_FRAME_HEIGHT, height);
   endtask

   // Right after reset the block runs at 1920 x 1080; only the first three
   // macropixels of row zero are sent here: all-zero, all-one and a mixed pattern.
   task automatic test_default_geometry();
      send_macropixel(8'h00, 8'h00, 8'h00, 8'h00);
      send_macropixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_macropixel(8'hA5, 8'h5A, 8'h3C, 8'hC3);
      drain_results();
   endtask

   // Smallest frame, one macropixel per line. Each pair of rows exercises
   // the averaging: both extremes, the truncated odd sum and a plain value.
   // Every frame ends with frame_done and the counters wrap.
   task automatic test_chroma_average();
      set_geometry(13'd2, 13'd2);
      send_macropixel(8'h10, 8'hFF, 8'h20, 8'h00);
      send_macropixel(8'h30, 8'hFF, 8'h40, 8'h00);
      send_macropixel(8'hFF, 8'h01, 8'h00, 8'hFE);
      send_macropixel(8'h00, 8'h00, 8'hFF, 8'hFF);
      send_macropixel(8'h55, 8'h00, 8'hAA, 8'h80);
      send_macropixel(8'hAA, 8'h00, 8'h55, 8'h80);
      drain_results();
   endtask

   // Register values outside the legal range: zero and one clamp up to two,
   // odd values round down, and anything above the maximum clamps to it.
   task automatic test_dimension_clamping();
      set_geometry(13'd0, 13'd1);
      repeat (2) send_random_macropixel();
      drain_results();
      set_geometry(13'd5, 13'd3);
      repeat (4) send_random_macropixel();
      drain_results();
      set_geometry(13'h1FFF, 13'd2);
      send_macropixel(8'h00, 8'hFF, 8'h00, 8'hFF);
      send_macropixel(8'hFF, 8'h00, 8'hFF, 8'h00);
      drain_results();
      set_geometry(13'd2, 13'd4097);
      repeat (2) send_random_macropixel();
      drain_results();
   endtask

   // Rewriting a geometry register in the middle of a frame restarts it,
   // while a write to an unused index leaves the counters where they are.
   task automatic test_frame_restart();
      set_geometry(13'd4, 13'd4);
      repeat (3) send_random_macropixel();
      drain_results();
      write_register(yti_pkg::CSR_LINE_WIDTH, 13'd4);
      repeat (2) send_random_macropixel();
      drain_results();
      write_register(CSR_UNUSED_INDEX, 13'($urandom));
      send_random_macropixel();
      drain_results();
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering macropixels, so the block has to stall its input.
   task automatic test_output_backpressure();
      set_geometry(13'd8, 13'd4);
      hold_request = 1'b1;
      repeat (32) send_random_macropixel();
      drain_results();
   endtask

   function automatic logic [FW-1:0] pick_dimension();
      case ($urandom_range(0, 9))
         0: return FW'($urandom_range(0, 1));
         1: return FW'($urandom_range(3, 9));
         default: return FW'(2 * $urandom_range(1, 4));
      endcase
   endfunction

   // Mostly complete frames of random small geometry with random pixels.
   // Now and then a frame is cut short by the next register write.
   task automatic run_random_frames(input int unsigned item_target);
      int unsigned sent;
      int unsigned count;
      sent = 0;
      while (sent < item_target) begin
         drain_results();
         case ($urandom_range(0, 3))
            0: write_register(yti_pkg::CSR_LINE_WIDTH, pick_dimension());
            1: write_register(yti_pkg::CSR_FRAME_HEIGHT, pick_dimension());
            default: set_geometry(pick_dimension(), pick_dimension());
         endcase
         count = effective_dimension(line_width_reg, MAX_W) / 2
                 * effective_dimension(frame_height_reg, MAX_H)
                 * $urandom_range(1, 2);
         if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);
         if (count > item_target - sent) count = item_target - sent;
         repeat (count) send_random_macropixel();
         sent += count;
      end
      drain_results();
   endtask

   // Receiver side: random stall bursts, or one long hold-off on request.
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Every accepted result transaction is matched against the oldest
   // predicted byte.
   always @(posedge clock) begin : result_check
      planar_byte_type want;
      planar_byte_type seen;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = '{rsp_tuser[PW-1:0], rsp_tdata[OW-1:0],
                  rsp_tdata[yti_pkg::RSP_DATA_W-1:OW], rsp_tlast, rsp_tuser[PW]};
         if (expected_bytes.size() == 0) begin
            report_failure($sformatf("unexpected byte plane %0d offset %0d value %02h",
                                     seen.plane, seen.offset, seen.value));
         end else begin
            want = expected_bytes.pop_front();
            if (seen.plane !== want.plane || seen.offset !== want.offset ||
                seen.value !== want.value || seen.last !== want.last ||
                seen.done !== want.done) begin
               report_failure({
                  $sformatf("mismatch: expected plane %0d offset %0d value %02h last %b done %b",
                            want.plane, want.offset, want.value, want.last, want.done),
                  $sformatf(", got plane %0d offset %0d value %02h last %b done %b",
                            seen.plane, seen.offset, seen.value, seen.last, seen.done)});
            end
         end
      end
   end

   initial begin : main
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_geometry();
      test_chroma_average();
      test_dimension_clamping();
      test_frame_restart();
      run_random_frames(40);
      test_output_backpressure();
      run_random_frames(30);
      // The closing stretch runs with both sides at full speed.
      idle_on = 1'b0;
      run_random_frames(25);

      drain_results();
      repeat (8) @(posedge clock);
      if (expected_bytes.size() != 0) begin
         report_failure($sformatf("%0d predicted bytes never arrived",
                                  expected_bytes.size()));
      end
      if (failure_count == 0) begin
         $display("yuyv422_to_i420_converter verification clean");
      end else begin
         $display("yuyv422_to_i420_converter verification failed");
      end
      $finish;
   end

   // The watchdog ends a run that hangs and reports it as failed.
   initial begin : watchdog
      #400000;
      $display("yuyv422_to_i420_converter verification failed");
      $finish;
   end

endmodule
